### src/assert_macros.svh
// Assertion macros shared by the cache RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define LKV_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define LKV_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### src/lkv_pkg.sv
// Shared types and constants for the LRU key/value cache.
// No dependencies; used by lkv_engine and lru_key_value_cache.
package lkv_pkg;

  // Number of entries in the cache storage.
  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int RANK_W      = IDX_W;
  localparam int DATA_W      = 32;
  localparam int CAP_W       = 5;
  localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;

  // Operation codes.
  localparam logic OP_GET = 1'b0;
  localparam logic OP_SET = 1'b1;

  typedef struct packed {
    logic              op;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] read_value;
    logic              evicted;
  } res_t;

  // One stored entry: key, value and recency rank (0 = most recent).
  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] key;
  } entry_t;

endpackage

### src/lkv_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lkv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

### src/lkv_engine.sv
// Lookup and replacement engine: scans the entry RAM, decides, then rewrites ranks.
// Depends on lkv_pkg, lkv_ram and assert_macros.svh.
`include "assert_macros.svh"

module lkv_engine (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [lkv_pkg::CAP_W-1:0] cap_i,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  lkv_pkg::req_t         req_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output lkv_pkg::res_t         res_o
);
  import lkv_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_UPD    = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 pend_q, pend_d;
  logic [IDX_W-1:0]     pend_idx_q, pend_idx_d;
  logic [MAX_ENTRIES-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]     occ_q, occ_d;
  logic                 found_q, found_d;
  logic                 have_old_q, have_old_d;

  logic                 op_q, op_d;
  logic [DATA_W-1:0]    key_q, key_d;
  logic [DATA_W-1:0]    val_q, val_d;
  logic [IDX_W-1:0]     found_idx_q, found_idx_d;
  logic [RANK_W-1:0]    found_rank_q, found_rank_d;
  logic [DATA_W-1:0]    found_val_q, found_val_d;
  logic [IDX_W-1:0]     old_idx_q, old_idx_d;
  logic [RANK_W-1:0]    old_rank_q, old_rank_d;
  logic [IDX_W-1:0]     tgt_idx_q, tgt_idx_d;
  logic [RANK_W-1:0]    thr_q, thr_d;
  logic [DATA_W-1:0]    new_val_q, new_val_d;
  res_t                 res_q, res_d;

  logic                 rd_en;
  logic                 wr_en;
  logic [IDX_W-1:0]     rd_addr;
  entry_t               wr_entry;
  entry_t               rd_entry;
  logic                 fill_ok;
  logic [CMP_W-1:0]     occ_x;
  logic [CMP_W-1:0]     cap_x;

  // Entry storage.
  lkv_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(MAX_ENTRIES)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(pend_idx_q),
    .wr_data_i(wr_entry),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_entry)
  );

  // A free entry may be filled while occupancy is below the clamped capacity.
  assign occ_x   = CMP_W'(occ_q);
  assign cap_x   = CMP_W'(cap_i);
  assign fill_ok = (occ_q < CNT_W'(MAX_ENTRIES)) &&
                   ((occ_x < cap_x) || ((cap_i == '0) && (occ_q == '0)));

  assign rd_addr     = cnt_q[IDX_W-1:0];
  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  // Sequencing, scan bookkeeping and the read-modify-write pass.
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    pend_d       = 1'b0;
    pend_idx_d   = rd_addr;
    valid_d      = valid_q;
    occ_d        = occ_q;
    found_d      = found_q;
    have_old_d   = have_old_q;
    op_d         = op_q;
    key_d        = key_q;
    val_d        = val_q;
    found_idx_d  = found_idx_q;
    found_rank_d = found_rank_q;
    found_val_d  = found_val_q;
    old_idx_d    = old_idx_q;
    old_rank_d   = old_rank_q;
    tgt_idx_d    = tgt_idx_q;
    thr_d        = thr_q;
    new_val_d    = new_val_q;
    res_d        = res_q;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    wr_entry     = rd_entry;

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          op_d       = req_i.op;
          key_d      = req_i.key;
          val_d      = req_i.value;
          found_d    = 1'b0;
          have_old_d = 1'b0;
          cnt_d      = '0;
          state_d    = S_SCAN;
        end
      end

      S_SCAN: begin
        // Issue one read a cycle; examine the entry read in the cycle before.
        if (cnt_q < CNT_W'(MAX_ENTRIES)) begin
          rd_en  = 1'b1;
          pend_d = 1'b1;
          cnt_d  = cnt_q + CNT_W'(1);
        end
        if (pend_q && valid_q[pend_idx_q]) begin
          if (!found_q && (rd_entry.key == key_q)) begin
            found_d      = 1'b1;
            found_idx_d  = pend_idx_q;
            found_rank_d = rd_entry.rank;
            found_val_d  = rd_entry.value;
          end
          if (!have_old_q || (rd_entry.rank >= old_rank_q)) begin
            have_old_d = 1'b1;
            old_idx_d  = pend_idx_q;
            old_rank_d = rd_entry.rank;
          end
        end
        if (cnt_q == CNT_W'(MAX_ENTRIES)) begin
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        res_d.hit        = found_q;
        res_d.evicted    = 1'b0;
        res_d.read_value = MISS_VALUE;
        cnt_d            = '0;
        state_d          = S_UPD;
        if (op_q == OP_GET) begin
          tgt_idx_d = found_idx_q;
          thr_d     = found_rank_q;
          new_val_d = found_val_q;
          if (found_q) begin
            res_d.read_value = found_val_q;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          res_d.read_value = val_q;
          new_val_d        = val_q;
          if (found_q) begin
            tgt_idx_d = found_idx_q;
            thr_d     = found_rank_q;
          end else if (fill_ok) begin
            tgt_idx_d = occ_q[IDX_W-1:0];
            thr_d     = occ_q[RANK_W-1:0];
            valid_d[occ_q[IDX_W-1:0]] = 1'b1;
            occ_d     = occ_q + CNT_W'(1);
          end else begin
            tgt_idx_d     = old_idx_q;
            thr_d         = old_rank_q;
            res_d.evicted = 1'b1;
          end
        end
      end

      S_UPD: begin
        // Target becomes most recent; younger valid entries age by one.
        if (cnt_q < CNT_W'(MAX_ENTRIES)) begin
          rd_en  = 1'b1;
          pend_d = 1'b1;
          cnt_d  = cnt_q + CNT_W'(1);
        end
        if (pend_q) begin
          if (pend_idx_q == tgt_idx_q) begin
            wr_en          = 1'b1;
            wr_entry.key   = key_q;
            wr_entry.value = new_val_q;
            wr_entry.rank  = '0;
          end else if (valid_q[pend_idx_q] && (rd_entry.rank < thr_q)) begin
            wr_en         = 1'b1;
            wr_entry.rank = rd_entry.rank + RANK_W'(1);
          end
        end
        if (cnt_q == CNT_W'(MAX_ENTRIES)) begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      pend_q     <= 1'b0;
      valid_q    <= '0;
      occ_q      <= '0;
      found_q    <= 1'b0;
      have_old_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      pend_q     <= pend_d;
      valid_q    <= valid_d;
      occ_q      <= occ_d;
      found_q    <= found_d;
      have_old_q <= have_old_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pend_idx_q   <= pend_idx_d;
    op_q         <= op_d;
    key_q        <= key_d;
    val_q        <= val_d;
    found_idx_q  <= found_idx_d;
    found_rank_q <= found_rank_d;
    found_val_q  <= found_val_d;
    old_idx_q    <= old_idx_d;
    old_rank_q   <= old_rank_d;
    tgt_idx_q    <= tgt_idx_d;
    thr_q        <= thr_d;
    new_val_q    <= new_val_d;
    res_q        <= res_d;
  end

  // Valid entries always form a prefix counted by the occupancy register.
  `LKV_ASSERT(a_occ_matches_valid, ($countones(valid_q) == occ_q), "occupancy mismatch")
  `LKV_ASSERT(a_occ_bound, (occ_q <= CNT_W'(MAX_ENTRIES)), "occupancy above depth")
  // The write-back never lands on the entry being read in the same cycle.
  `LKV_ASSERT(a_no_rw_clash, (wr_en && rd_en |-> pend_idx_q != rd_addr), "RAM read/write clash")
  // Eviction only ever picks an entry that the scan saw as valid.
  `LKV_ASSERT(a_evict_has_victim, ((state_q == S_DECIDE) && (op_q == OP_SET) && !found_q && !fill_ok |-> have_old_q), "eviction without victim")

endmodule

### src/lru_key_value_cache.sv
// Fully associative LRU key/value cache, top level.
// Depends on lkv_pkg and lkv_engine (which uses lkv_ram).
//
// Usage:
//   Requests arrive on the s_axis channel: tuser[0] is the opcode (0 = get,
//   1 = set), tdata[31:0] the key and tdata[63:32] the value to store.
//   Each request gives exactly one result on m_axis: tdata is the read value
//   (stored value on a get hit, all ones on a get miss, the written value on
//   a set), tuser[0] the hit flag and tuser[1] the eviction flag.
//   The cfg channel writes the capacity in use (5 bits, 0 acts as 1, values
//   above the storage depth act as the depth); it is always ready and is to
//   be written only while no request is in progress.
// Timing:
//   All entries sit in one RAM with registered read data. A request scans
//   the RAM one entry a cycle, decides, then, except on a get miss, makes a
//   second read-modify-write pass over the RAM to update recency ranks.
//   One request at a time: the next is taken only once the engine has handed
//   the previous result to the output register.
// Reset and stall:
//   Reset empties the cache and sets the capacity to 16. A result waits in the
//   output register while m_axis_tready is low; the next request is still
//   taken and processed, and holds at its end until the register is free.
module lru_key_value_cache (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Configuration write channel.
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [lkv_pkg::CAP_W-1:0] cfg_data_i,   // capacity_in_use
  // Request stream.
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [63:0]               s_axis_tdata,  // [31:0] lookup_key, [63:32] write_value
  input  logic [0:0]                s_axis_tuser,  // [0] opcode
  // Result stream.
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [31:0]               m_axis_tdata,  // [31:0] read_value
  output logic [1:0]                m_axis_tuser   // [0] hit, [1] evicted
);
  import lkv_pkg::*;

  logic [CAP_W-1:0] cap_q;
  logic             out_valid_q;
  res_t             out_q;
  req_t             req;
  res_t             res;
  logic             res_valid;
  logic             res_ready;

  // Capacity register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // Unpack the request.
  assign req.op    = s_axis_tuser[0];
  assign req.key   = s_axis_tdata[31:0];
  assign req.value = s_axis_tdata[63:32];

  lkv_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cap_i      (cap_q),
    .req_valid_i(s_axis_tvalid),
    .req_ready_o(s_axis_tready),
    .req_i      (req),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  // Output register: loads when empty or when its result transfers.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_q.read_value;
  assign m_axis_tuser[0] = out_q.hit;
  assign m_axis_tuser[1] = out_q.evicted;

endmodule

### tb/sv/lru_key_value_cache_test.sv
// Self-checking testbench for the LRU key/value cache top level.
// Depends on lkv_pkg and the cache RTL; drives requests and capacity writes,
// predicts every result in its own model of the cache and checks each one.
module lru_key_value_cache_test;
  import lkv_pkg::*;

  localparam int HALF_PERIOD     = 5;
  localparam int RESET_CYCLES    = 5;
  localparam int RX_STALL_CYCLES = 400;
  localparam int PHASE_ITEMS     = 122;
  localparam int KEY_POOL_SIZE   = 24;
  localparam int SETTLE_CYCLES   = 2 * MAX_ENTRIES + 5;
  localparam longint TIMEOUT_TIME = 64'd5_000_000;

  // Clock, reset and block ports.
  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_valid_i   = 1'b0;
  logic              cfg_ready_o;
  logic [CAP_W-1:0]  cfg_data_i    = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [63:0]       s_axis_tdata  = '0;  // [31:0] lookup_key, [63:32] write_value
  logic [0:0]        s_axis_tuser  = '0;  // [0] opcode
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [31:0]       m_axis_tdata;        // [31:0] read_value
  logic [1:0]        m_axis_tuser;        // [0] hit, [1] evicted

  // Requests waiting to be offered and results waiting to arrive.
  req_t              request_queue[$];
  res_t              expected_results[$];
  req_t              offered_req;
  int unsigned       queued_count   = 0;
  int unsigned       accepted_count = 0;
  int unsigned       result_count   = 0;
  int unsigned       error_count    = 0;

  // Idling controls: the sequencer sets rates and stall requests, the monitor serves the stalls.
  int unsigned       send_idle_pct  = 33;
  int unsigned       recv_idle_pct  = 69;
  int unsigned       stall_requests = 0;
  int unsigned       stall_served   = 0;
  int unsigned       stall_left     = 0;

  // Mirror of the cache contents used for prediction.
  logic [DATA_W-1:0] line_key   [MAX_ENTRIES];
  logic [DATA_W-1:0] line_value [MAX_ENTRIES];
  logic              line_valid [MAX_ENTRIES];
  logic [RANK_W-1:0] line_rank  [MAX_ENTRIES];
  logic [CNT_W-1:0]  line_count = '0;
  logic [CAP_W-1:0]  capacity_setting = CAP_RESET;

  logic [DATA_W-1:0] key_pool [KEY_POOL_SIZE];

  lru_key_value_cache i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Free-running clock.
  always #HALF_PERIOD clk_i = ~clk_i;

  // Make one entry the most recent; every younger valid entry ages by one.
  function automatic void promote_line(input int idx);
    logic [RANK_W-1:0] old_rank;
    old_rank = line_rank[idx];
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (line_valid[i] && line_rank[i] < old_rank) begin
        line_rank[i] = line_rank[i] + 1'b1;
      end
    end
    line_rank[idx] = '0;
  endfunction

  // Capacity as the block applies it: zero acts as one, large values saturate.
  function automatic int usable_capacity();
    int cap;
    cap = int'(capacity_setting);
    if (cap == 0) cap = 1;
    if (cap > MAX_ENTRIES) cap = MAX_ENTRIES;
    return cap;
  endfunction

  // Apply one request to the mirror and return the result it must give.
  function automatic res_t cache_lookup_update(input req_t req);
    res_t              res;
    logic              present;
    int                slot;
    int                victim;
    logic [RANK_W-1:0] oldest_rank;
    present = 1'b0;
    slot    = 0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (!present && line_valid[i] && line_key[i] == req.key) begin
        present = 1'b1;
        slot    = i;
      end
    end
    res.hit        = present;
    res.read_value = MISS_VALUE;
    res.evicted    = 1'b0;
    if (req.op == OP_GET) begin
      if (present) begin
        res.read_value = line_value[slot];
        promote_line(slot);
      end
    end else begin
      res.read_value = req.value;
      if (present) begin
        line_value[slot] = req.value;
        promote_line(slot);
      end else if (int'(line_count) < usable_capacity()) begin
        // A free entry remains: fill entries in index order.
        slot             = int'(line_count);
        line_key[slot]   = req.key;
        line_value[slot] = req.value;
        line_valid[slot] = 1'b1;
        line_rank[slot]  = RANK_W'(line_count);
        line_count       = line_count + 1'b1;
        promote_line(slot);
      end else begin
        // Full: replace the least recently used entry, the highest index on a tie.
        victim      = 0;
        oldest_rank = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (line_valid[i] && line_rank[i] >= oldest_rank) begin
            oldest_rank = line_rank[i];
            victim      = i;
          end
        end
        line_key[victim]   = req.key;
        line_value[victim] = req.value;
        line_valid[victim] = 1'b1;
        promote_line(victim);
        res.evicted = 1'b1;
      end
    end
    return res;
  endfunction

  // One line per mismatch, and a count of them.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("%0t: %s mismatch on result %0d: got %h, expected %h",
             $realtime, what, result_count, got, want);
  endtask

  // Request driver: offers queued requests, predicting each one on transfer.
  always @(posedge clk_i) begin : request_driver
    logic next_valid;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(cache_lookup_update(offered_req));
        accepted_count++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        next_valid = 1'b0;
        if (request_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          offered_req = request_queue.pop_front();
          next_valid  = 1'b1;
          s_axis_tdata <= {offered_req.value, offered_req.key};
          s_axis_tuser <= offered_req.op;
        end
        s_axis_tvalid <= next_valid;
      end
    end
  end

  // Result monitor: checks each transfer against the oldest expectation and
  // drives the ready, including long hold-offs on request.
  always @(posedge clk_i) begin : result_monitor
    res_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        result_count++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata, '0);
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tuser[0] !== want.hit) begin
            report_mismatch("hit", 32'(m_axis_tuser[0]), 32'(want.hit));
          end
          if (m_axis_tdata !== want.read_value) begin
            report_mismatch("read_value", m_axis_tdata, want.read_value);
          end
          if (m_axis_tuser[1] !== want.evicted) begin
            report_mismatch("evicted", 32'(m_axis_tuser[1]), 32'(want.evicted));
          end
        end
      end
      if (stall_requests != stall_served) begin
        stall_left = RX_STALL_CYCLES;
        stall_served++;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Hard limit on the run time.
  initial begin : run_limit
    #(TIMEOUT_TIME);
    $display("RESULT: ERROR");
    $finish;
  end

  // Stimulus sequencer.
  initial begin : sequencer
    int cap_plan[9];
    int chunk;
    int sent;
    int pool_n;
    cap_plan = '{16, 3, 1, 31, 8, 0, 12, 5, 16};
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      line_key[i]   = '0;
      line_value[i] = '0;
      line_valid[i] = 1'b0;
      line_rank[i]  = '0;
    end
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < KEY_POOL_SIZE; i++) begin
      key_pool[i] = $urandom;
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset capacity: empty miss, fills, hits on the
    // oldest and the newest entry, an update, and a hit on an all-ones value.
    queue_request(OP_GET, 32'h0000_0000, 32'h1234_5678);
    queue_request(OP_SET, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_request(OP_SET, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_request(OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(OP_GET, 32'h8000_0000, 32'h0000_0000);
    queue_request(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    queue_request(OP_SET, 32'h7FFF_FFFF, 32'h0000_0000);
    queue_request(OP_GET, 32'h7FFF_FFFF, 32'h5555_5555);
    queue_request(OP_GET, 32'h0000_0001, 32'hAAAA_AAAA);
    queue_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    wait_until_drained();

    // Capacity lowered below occupancy: new keys evict, updates do not.
    write_capacity(CAP_W'(2));
    queue_request(OP_SET, 32'h1234_5678, 32'h0F0F_0F0F);
    queue_request(OP_GET, 32'h8000_0000, 32'h0000_0000);
    queue_request(OP_SET, 32'h7FFF_FFFF, 32'hA5A5_A5A5);
    queue_request(OP_SET, 32'h0000_0000, 32'h0000_0000);
    queue_request(OP_GET, 32'h1234_5678, 32'hFFFF_FFFF);
    wait_until_drained();

    // Capacity zero acts as one.
    write_capacity(CAP_W'(0));
    queue_request(OP_SET, 32'h0000_0042, 32'h5A5A_5A5A);
    queue_request(OP_GET, 32'h0000_0042, 32'h0000_0000);
    wait_until_drained();

    // Capacity above the storage depth saturates: free entries fill again.
    write_capacity(CAP_W'(31));
    queue_request(OP_SET, 32'h0000_0100, 32'h0000_0001);
    queue_request(OP_SET, 32'h0000_0200, 32'h0000_0002);
    queue_request(OP_GET, 32'h0000_0100, 32'h0000_0000);
    queue_request(OP_GET, 32'hDEAD_BEEF, 32'h0000_0000);
    wait_until_drained();

    // Random phases, one capacity each, three idling modes in turn.
    for (int phase = 0; phase < 9; phase++) begin
      write_capacity(CAP_W'(cap_plan[phase]));
      case (phase / 3)
        0: begin
          send_idle_pct = 33;
          recv_idle_pct = 69;
        end
        1: begin
          send_idle_pct = 69;
          recv_idle_pct = 33;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      pool_n = usable_capacity() + 4;
      if (pool_n > KEY_POOL_SIZE) pool_n = KEY_POOL_SIZE;
      // Long receiver hold-off while the sender keeps offering.
      if (phase == 0 || phase == 6) stall_requests++;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        chunk = $urandom_range(40, 10);
        if (chunk > PHASE_ITEMS - sent) chunk = PHASE_ITEMS - sent;
        for (int n = 0; n < chunk; n++) begin
          queue_request(($urandom_range(99) < 55) ? OP_SET : OP_GET,
                        pick_key(pool_n), pick_value());
        end
        sent += chunk;
        // Sometimes the sender pauses until every result is back.
        if ($urandom_range(1) == 0) begin
          wait_until_drained();
        end else begin
          while (request_queue.size() != 0) @(posedge clk_i);
        end
      end
      wait_until_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Queue one request for the driver.
  task automatic queue_request(input logic op, input logic [31:0] key,
                               input logic [31:0] value);
    req_t req;
    req.op    = op;
    req.key   = key;
    req.value = value;
    request_queue.push_back(req);
    queued_count++;
  endtask

  // Wait until every queued request has been taken and answered.
  task automatic wait_until_drained();
    do @(posedge clk_i);
    while (accepted_count != queued_count || expected_results.size() != 0);
  endtask

  // Write the capacity register; only called while the block is idle.
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    capacity_setting = cap;
  endtask

  // Keys mostly come from a small pool so that hits and evictions are common.
  function automatic logic [31:0] pick_key(input int pool_n);
    if ($urandom_range(9) == 0) return $urandom;
    return key_pool[$urandom_range(pool_n - 1)];
  endfunction

  // Values are random with an occasional extreme.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(15))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

endmodule

### files.f
+incdir+src
src/lkv_pkg.sv
src/lkv_ram.sv
src/lkv_engine.sv
src/lru_key_value_cache.sv
tb/sv/lru_key_value_cache_test.sv
